// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
// Types and codes shared by the sorted priority queue files.
// Depends on nothing.
package spq_pkg;

   // operation codes
   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_POP_HIGH = 2'd1,
      OP_POP_LOW  = 2'd2,
      OP_POP_PRI  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] item_value;
      logic signed [15:0] item_priority;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      status_type         status;
      logic [4:0]         entry_count;
   } rsp_word_type;

   // one table slot
   typedef struct packed {
      logic signed [31:0] slot_value;
      logic signed [15:0] slot_priority;
   } entry_type;

endpackage

// ----- src/spq_table.sv -----
`timescale 1ns / 1ps
// Slot table: one write port, one read port with registered read data.
// Depends on spq_pkg for the slot type.
module spq_table #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output spq_pkg::entry_type       rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  spq_pkg::entry_type       wr_data
);
   import spq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// A push walks from the tail down, moving each entry of lower priority up one slot, then
//   writes the new entry; head and priority pops walk from head to tail, closing the gap;
//   a tail pop reads only the tail; a refused push or empty pop goes straight to the result.
// Throughput: one operation at a time; the next word is taken the cycle after the result
//   loads, and a finished result waits while the output register is stalled.
// Reset: synchronous, clears the fill count and control; the table is not cleared.
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_word_type rsp_word
);
   import spq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_PUSH      = 5'b00010,
      S_PUSH_LAST = 5'b00100,
      S_POP       = 5'b01000,
      S_DONE      = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          more_ff, more_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          found_ff, found_in;
   logic          any_ff, any_in;
   logic [CW-1:0] count_ff, count_in;
   req_word_type  req_ff, req_in;
   rsp_word_type  res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   entry_type     new_entry;

   logic [CW-1:0] count_dec;
   logic [AW-1:0] last_idx;
   logic [CW+4:0] count_wide;
   logic          hit;

   assign count_dec  = count_ff - CW'(1);
   assign last_idx   = count_dec[AW-1:0];
   assign count_wide = {5'd0, count_ff};
   assign new_entry  = '{slot_value: req_ff.item_value, slot_priority: req_ff.item_priority};
   assign hit = rd_vld_ff && !found_ff &&
                (any_ff || (rd_data.slot_priority == req_ff.item_priority));

   spq_table #(
      .DEPTH(DEPTH)
   ) u_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   // sequencer: walk the table one entry a cycle, shift entries, build the result
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      more_in      = more_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      any_in       = any_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = new_entry;

      // drop the output word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               res_in   = '{removed_value: '0, status: ST_OK, entry_count: '0};
               found_in = 1'b0;
               any_in   = (req_word.op != OP_POP_PRI);
               more_in  = 1'b1;
               if (req_word.op == OP_PUSH) begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_in.status = ST_FULL;
                     state_in      = S_DONE;
                  end else if (count_ff == '0) begin
                     state_in = S_PUSH_LAST;
                  end else begin
                     ptr_in   = last_idx;
                     state_in = S_PUSH;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     ptr_in   = (req_word.op == OP_POP_LOW) ? last_idx : '0;
                     state_in = S_POP;
                  end
               end
            end
         end

         S_PUSH: begin
            // issue reads from the tail down
            if (more_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff;
               if (ptr_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - AW'(1);
               end
            end
            // move each lower entry up one slot, toward the tail, until the insert point
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff + AW'(1);
               if (rd_data.slot_priority >= req_ff.item_priority) begin
                  wr_data   = new_entry;
                  rd_en     = 1'b0;
                  rd_vld_in = 1'b0;
                  more_in   = 1'b0;
                  count_in  = count_ff + CW'(1);
                  state_in  = S_DONE;
               end else begin
                  wr_data = rd_data;
                  if (rd_idx_ff == '0) begin
                     state_in = S_PUSH_LAST;
                  end
               end
            end
         end

         S_PUSH_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_entry;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end

         S_POP: begin
            // issue reads from the start point up to the tail
            if (more_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = ptr_ff;
               if (ptr_ff == last_idx) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
            if (rd_vld_ff) begin
               // capture the removed entry, close the gap behind it
               if (hit) begin
                  found_in             = 1'b1;
                  res_in.removed_value = rd_data.slot_value;
               end else if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = rd_idx_ff - AW'(1);
                  wr_data = rd_data;
               end
               if (rd_idx_ff == last_idx) begin
                  if (found_ff || hit) begin
                     count_in = count_dec;
                  end else begin
                     res_in.status = ST_NOT_FOUND;
                  end
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            // hand the result to the output register when it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = res_ff;
               rsp_in.entry_count = count_wide[4:0];
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         more_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         more_ff      <= more_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      rd_idx_ff <= rd_idx_in;
      any_ff    <= any_in;
      req_ff    <= req_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   // the count never runs past the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   // a walk never writes the slot it reads in the same cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("table read and write hit the same slot");

   // a refused push only happens on a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status == ST_FULL) |-> (count_ff == CW'(DEPTH)))
      else $error("full status with free slots");

   // an empty report leaves the count at zero
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status == ST_EMPTY) |-> (count_ff == '0))
      else $error("empty status with entries held");
`endif

endmodule
